FILE: rtl/mmn_pkg.sv
// ----------------------------------------------------------------------------
// mmn_pkg
// shared constants and controller-to-datapath command type for the
// min-max byte normalizer
// ----------------------------------------------------------------------------
package mmn_pkg;

  localparam int MAX_COLORS_DEF  = 4;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF   = 12;

  // tracker reset magnitude in whole units, scaled by the fraction bits
  localparam longint TRACK_BOUND_INT = 1024;

  localparam int CFG_W   = 3;
  localparam int CHAN_W  = 2;
  localparam int PIX_W   = 8;
  localparam int STEP_W  = $clog2(PIX_W);

  localparam logic [CFG_W-1:0] NUM_COLORS_RST = 3'd1;

  localparam logic MODE_GATHER = 1'b0;
  localparam logic MODE_EMIT   = 1'b1;

  typedef struct packed {
    logic take;      // any input beat accepted
    logic gather;    // accepted beat belongs to a gather pass
    logic emit;      // accepted beat belongs to an emit pass
    logic prep;      // scale numerator, set special-case flags
    logic div_step;  // one restoring division step
    logic load_out;  // move the result into the output register
  } mmn_cmd_t;

endpackage

FILE: rtl/mmn_ctrl.sv
// ----------------------------------------------------------------------------
// mmn_ctrl
// sequencer for one emit beat: prepare, eight divide steps, hand-off to
// the output register; gather beats finish in their accept cycle
// ----------------------------------------------------------------------------
module mmn_ctrl
  import mmn_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_valid,
  input  logic     s_mode,
  output logic     s_ready,
  output logic     m_valid,
  input  logic     m_ready,
  output mmn_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] step_cnt;
  logic              out_free;

  assign s_ready  = (state == ST_IDLE);
  assign out_free = !m_valid || m_ready;

  always_comb begin
    cmd          = '0;
    cmd.take     = s_valid && s_ready;
    cmd.gather   = cmd.take && (s_mode == MODE_GATHER);
    cmd.emit     = cmd.take && (s_mode == MODE_EMIT);
    cmd.prep     = (state == ST_PREP);
    cmd.div_step = (state == ST_DIV);
    cmd.load_out = (state == ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
      m_valid  <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd.emit) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          step_cnt <= '0;
          state    <= ST_DIV;
        end
        ST_DIV: begin
          step_cnt <= step_cnt + STEP_W'(1);
          if (step_cnt == STEP_W'(PIX_W - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!m_valid || m_ready))
    else $error("result loaded over an untaken beat");

  a_emit_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (state == ST_PREP && !s_ready))
    else $error("emit beat did not start the sequencer");

  a_gather_fast: assert property (@(posedge clk) disable iff (rst)
    cmd.gather |=> s_ready)
    else $error("gather beat stalled the input");

  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_valid) |-> $past(cmd.load_out))
    else $error("output valid without a load");

endmodule

FILE: rtl/mmn_dp.sv
// ----------------------------------------------------------------------------
// mmn_dp
// channel counter, per-channel max/min trackers, offset/range subtract,
// restoring divider for the 8-bit quotient and the output register
// ----------------------------------------------------------------------------
module mmn_dp
  import mmn_pkg::*;
#(
  parameter int MAX_COLORS  = MAX_COLORS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mmn_cmd_t                      cmd,
  input  logic                          cfg_wr_en,
  input  logic [CFG_W-1:0]              cfg_wr_data,
  input  logic                          in_first,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic [PIX_W-1:0]              out_pixel,
  output logic [CHAN_W-1:0]             out_channel,
  output logic                          out_flat
);

  localparam int     SW        = SAMPLE_BITS;
  localparam longint SMP_HI    = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint BOUND_RAW = TRACK_BOUND_INT << FRAC_BITS;
  localparam longint BOUND     = (BOUND_RAW > SMP_HI) ? SMP_HI : BOUND_RAW;
  localparam logic signed [SW-1:0] MIN_INIT = SW'(BOUND);
  localparam logic signed [SW-1:0] MAX_INIT = SW'(-BOUND);

  logic [CFG_W-1:0]  num_colors;
  logic [CHAN_W-1:0] chan_index;
  logic signed [SW-1:0] chan_max [MAX_COLORS];
  logic signed [SW-1:0] chan_min [MAX_COLORS];

  logic [CFG_W-1:0]     nc;
  logic [CHAN_W-1:0]    c_base;
  logic [CHAN_W-1:0]    c_sel;
  logic [CHAN_W-1:0]    c_next;
  logic signed [SW-1:0] rd_max;
  logic signed [SW-1:0] rd_min;
  logic signed [SW:0]   num_d;
  logic signed [SW:0]   den_d;

  // emit working registers
  logic signed [SW:0]   num_r;
  logic signed [SW:0]   den_r;
  logic [CHAN_W-1:0]    chan_r;
  logic                 zero_r;
  logic                 sat_r;
  logic                 flat_r;
  logic [SW-1:0]        du_r;
  logic [SW-1:0]        rem;
  logic [PIX_W-1:0]     nlow;
  logic [PIX_W-1:0]     quo;

  logic [SW-1:0]        nu;
  logic [SW+PIX_W-1:0]  n_scaled;
  logic [SW:0]          trial;
  logic                 num_le0;
  logic                 den_le0;

  // channel selection with clamped channel count
  always_comb begin
    if (num_colors == '0) begin
      nc = CFG_W'(1);
    end else if (num_colors > CFG_W'(MAX_COLORS)) begin
      nc = CFG_W'(MAX_COLORS);
    end else begin
      nc = num_colors;
    end
    c_base = in_first ? '0 : chan_index;
    c_sel  = (CFG_W'(c_base) >= nc) ? '0 : c_base;
    c_next = ((CFG_W'(c_sel) + CFG_W'(1)) >= nc) ? '0 : c_sel + CHAN_W'(1);
  end

  always_comb begin
    rd_max = chan_max[0];
    rd_min = chan_min[0];
    for (int i = 0; i < MAX_COLORS; i++) begin
      if (CHAN_W'(i) == c_sel) begin
        rd_max = chan_max[i];
        rd_min = chan_min[i];
      end
    end
    num_d = {in_sample[SW-1], in_sample} - {rd_min[SW-1], rd_min};
    den_d = {rd_max[SW-1], rd_max} - {rd_min[SW-1], rd_min};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_colors <= NUM_COLORS_RST;
      chan_index <= '0;
      for (int i = 0; i < MAX_COLORS; i++) begin
        chan_max[i] <= MAX_INIT;
        chan_min[i] <= MIN_INIT;
      end
    end else begin
      if (cfg_wr_en) begin
        num_colors <= cfg_wr_data;
      end
      if (cmd.take) begin
        chan_index <= c_next;
      end
      if (cmd.gather) begin
        // a first beat clears every tracker before the sample is applied
        for (int i = 0; i < MAX_COLORS; i++) begin
          if (CHAN_W'(i) == c_sel) begin
            if (in_sample > (in_first ? MAX_INIT : chan_max[i])) begin
              chan_max[i] <= in_sample;
            end else if (in_first) begin
              chan_max[i] <= MAX_INIT;
            end
            if (in_sample < (in_first ? MIN_INIT : chan_min[i])) begin
              chan_min[i] <= in_sample;
            end else if (in_first) begin
              chan_min[i] <= MIN_INIT;
            end
          end else if (in_first) begin
            chan_max[i] <= MAX_INIT;
            chan_min[i] <= MIN_INIT;
          end
        end
      end
    end
  end

  // numerator times 255 as a shift and subtract
  assign nu       = num_r[SW-1:0];
  assign n_scaled = {nu, PIX_W'(0)} - {PIX_W'(0), nu};
  assign trial    = {rem, nlow[PIX_W-1]};
  assign num_le0  = num_r[SW] || (num_r == '0);
  assign den_le0  = den_r[SW] || (den_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      num_r  <= num_d;
      den_r  <= den_d;
      chan_r <= c_sel;
    end
    if (cmd.prep) begin
      flat_r <= den_le0;
      zero_r <= den_le0 || num_le0;
      // offset at or above the range saturates
      sat_r  <= (num_r >= den_r);
      du_r   <= den_r[SW-1:0];
      rem    <= n_scaled[SW+PIX_W-1:PIX_W];
      nlow   <= n_scaled[PIX_W-1:0];
    end
    if (cmd.div_step) begin
      if (trial >= {1'b0, du_r}) begin
        rem <= SW'(trial - {1'b0, du_r});
        quo <= {quo[PIX_W-2:0], 1'b1};
      end else begin
        rem <= trial[SW-1:0];
        quo <= {quo[PIX_W-2:0], 1'b0};
      end
      nlow <= {nlow[PIX_W-2:0], 1'b0};
    end
    if (cmd.load_out) begin
      out_channel <= chan_r;
      out_flat    <= flat_r;
      if (zero_r) begin
        out_pixel <= '0;
      end else if (sat_r) begin
        out_pixel <= '1;
      end else begin
        out_pixel <= quo;
      end
    end
  end

endmodule

FILE: rtl/minmax_normalize_to_byte_unit.sv
// ----------------------------------------------------------------------------
// minmax_normalize_to_byte_unit
// per-channel min-max stretch of signed fixed-point samples to bytes
//
// channel  | direction | beat contents (low bit first)
// ---------+-----------+------------------------------------------------
// s_axis   | in        | tdata: sample; tuser: mode, first_of_pass
// m_axis   | out       | tdata: pixel; tuser: channel, flat
// cfg      | in        | cfg_wr_data: num_colors, written on cfg_wr_en
//
// gather beats return nothing and are taken one per cycle while idle
// an emit beat holds further input off until the sequencer is idle again:
// one subtract, one scaling step, eight restoring divide steps, one output hand-off
// the output register holds a result while the next beat is being worked on;
// a stalled output holds the sequencer only at its hand-off
// reset (rst, synchronous) restores trackers to +-1024 and num_colors to 1
// ----------------------------------------------------------------------------
module minmax_normalize_to_byte_unit
  import mmn_pkg::*;
#(
  parameter int  MAX_COLORS  = MAX_COLORS_DEF,
  parameter int  SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int  FRAC_BITS   = FRAC_BITS_DEF,
  localparam int IN_DATA_W   = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_W-1:0]     cfg_wr_data,   // num_colors
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,  // sample, zero pad
  input  logic [1:0]           s_axis_tuser,  // mode, first_of_pass
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [PIX_W-1:0]     m_axis_tdata,  // pixel
  output logic [CHAN_W:0]      m_axis_tuser   // channel, flat
);

  mmn_cmd_t          cmd;
  logic [CHAN_W-1:0] out_channel;
  logic              out_flat;

  mmn_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_mode  (s_axis_tuser[0]),
    .s_ready (s_axis_tready),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .cmd     (cmd)
  );

  mmn_dp #(
    .MAX_COLORS  (MAX_COLORS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_first    (s_axis_tuser[1]),
    .in_sample   (s_axis_tdata[SAMPLE_BITS-1:0]),
    .out_pixel   (m_axis_tdata),
    .out_channel (out_channel),
    .out_flat    (out_flat)
  );

  assign m_axis_tuser = {out_flat, out_channel};

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for minmax_normalize_to_byte_unit: directed beats for
// the range ends, flat channels, untracked emits and a shrinking channel
// count, then random gather/emit images under bursty input and stalled output
// ----------------------------------------------------------------------------
module tb_top;
  import mmn_pkg::*;

  localparam int SB          = SAMPLE_BITS_DEF;
  localparam int SETTLE      = 24;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_BEATS = 700;

  typedef logic signed [SB-1:0] sample_t;

  typedef struct {
    logic    mode;
    logic    first;
    sample_t smp;
  } sample_beat_t;

  typedef struct {
    logic [PIX_W-1:0]  pixel;
    logic [CHAN_W-1:0] channel;
    logic              flat;
  } byte_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [SB-1:0] s_axis_tdata = '0;   // sample
  logic [1:0] s_axis_tuser = '0;      // mode, first_of_pass
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [PIX_W-1:0] m_axis_tdata;     // pixel
  logic [CHAN_W:0] m_axis_tuser;      // channel, flat

  minmax_normalize_to_byte_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sample_beat_t sample_beats[$];
  byte_result_t expected_bytes[$];
  int errors = 0;
  int beats_queued = 0;

  // traffic knobs set per phase
  int gap_max = 4;
  bit rx_free = 1'b0;
  int hold_reqs = 0;

  // ---------------------------------------------------------------- predictor
  longint trk_max[MAX_COLORS_DEF];
  longint trk_min[MAX_COLORS_DEF];
  int chan_next;
  int colors_cfg;

  function automatic longint smp_hi();
    return (longint'(1) <<< (SB - 1)) - 1;
  endfunction

  task automatic clear_trackers();
    longint bound;
    longint nbound;
    bound = TRACK_BOUND_INT <<< FRAC_BITS_DEF;
    if (bound > smp_hi()) bound = smp_hi();
    nbound = -bound;
    if (nbound < -smp_hi() - 1) nbound = -smp_hi() - 1;
    for (int c = 0; c < MAX_COLORS_DEF; c++) begin
      trk_max[c] = nbound;
      trk_min[c] = bound;
    end
  endtask

  task automatic normalize_step(input sample_beat_t b);
    int nc;
    int c;
    longint x;
    longint den;
    longint num;
    longint q;
    byte_result_t r;
    nc = colors_cfg;
    if (nc < 1) nc = 1;
    if (nc > MAX_COLORS_DEF) nc = MAX_COLORS_DEF;
    if (b.first) begin
      chan_next = 0;
      if (b.mode == MODE_GATHER) clear_trackers();
    end
    c = chan_next;
    if (c >= nc) c = 0;
    chan_next = (c + 1 >= nc) ? 0 : c + 1;
    x = longint'(b.smp);
    if (b.mode == MODE_GATHER) begin
      // both ends are tested on every beat
      if (x > trk_max[c]) trk_max[c] = x;
      if (x < trk_min[c]) trk_min[c] = x;
    end else begin
      den = trk_max[c] - trk_min[c];
      num = x - trk_min[c];
      r.pixel = '0;
      r.flat = 1'b0;
      r.channel = c[CHAN_W-1:0];
      if (den <= 0) begin
        r.flat = 1'b1;
      end else if (num > 0) begin
        q = (num * 255) / den;
        r.pixel = (q > 255) ? 8'd255 : q[PIX_W-1:0];
      end
      expected_bytes.push_back(r);
    end
  endtask

  // ----------------------------------------------------- prediction and check
  always @(posedge clk) begin
    byte_result_t e;
    sample_beat_t b;
    if (rst) begin
      clear_trackers();
      chan_next = 0;
      colors_cfg = int'(NUM_COLORS_RST);
    end else begin
      if (cfg_wr_en) colors_cfg = int'(cfg_wr_data);
      if (s_axis_tvalid && s_axis_tready) begin
        b.mode = s_axis_tuser[0];
        b.first = s_axis_tuser[1];
        b.smp = s_axis_tdata;
        normalize_step(b);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_bytes.size() == 0) begin
          $error("output beat with nothing expected: pixel %0d", m_axis_tdata);
          errors++;
        end else begin
          e = expected_bytes.pop_front();
          if (m_axis_tdata !== e.pixel) begin
            $error("pixel: expected %0d, got %0d", e.pixel, m_axis_tdata);
            errors++;
          end
          if (m_axis_tuser[CHAN_W-1:0] !== e.channel) begin
            $error("channel: expected %0d, got %0d", e.channel, m_axis_tuser[CHAN_W-1:0]);
            errors++;
          end
          if (m_axis_tuser[CHAN_W] !== e.flat) begin
            $error("flat: expected %0d, got %0d", e.flat, m_axis_tuser[CHAN_W]);
            errors++;
          end
        end
      end
    end
  end

  // ------------------------------------------------------------------ driver
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    sample_beat_t b;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (sample_beats.size() > 0) begin
        b = sample_beats.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b.smp;
        s_axis_tuser <= {b.first, b.mode};
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  int hold_served = 0;
  int hold_left = 0;
  logic [15:0] stall_pat = 16'hffff;
  logic [5:0] pat_age = '0;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_reqs != hold_served) begin
      hold_served <= hold_served + 1;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rx_free ? 1'b1 : stall_pat[0];
      stall_pat <= (pat_age == 0) ? 16'($urandom) : {stall_pat[0], stall_pat[15:1]};
      pat_age <= pat_age + 1'b1;
    end
  end

  // --------------------------------------------------------------- stimulus
  task automatic add_beat(input logic mode, input logic first, input sample_t smp);
    sample_beat_t b;
    b.mode = mode;
    b.first = first;
    b.smp = smp;
    sample_beats.push_back(b);
    beats_queued++;
  endtask

  // no result is owed for gather beats, so settle past the block's latency too
  // sampled at the falling edge so the driver's and monitor's updates are in
  task automatic wait_idle();
    do
      @(negedge clk);
    while (sample_beats.size() != 0 || s_axis_tvalid || expected_bytes.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_colors(input int v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v[CFG_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic sample_t pick_sample(input longint base, input int unsigned span);
    int unsigned sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return sample_t'(smp_hi());
    if (sel == 1) return sample_t'(-smp_hi() - 1);
    if (sel < 5) return sample_t'($urandom);
    return sample_t'(base + longint'($urandom_range(0, span)));
  endfunction

  // one gather pass then one emit pass over an interleaved image
  task automatic queue_image(input int colors, input int pixels, input bit broken);
    longint base[MAX_COLORS_DEF];
    int unsigned span[MAX_COLORS_DEF];
    int unsigned pick;
    for (int c = 0; c < MAX_COLORS_DEF; c++) begin
      base[c] = longint'($urandom_range(0, 1 << 23)) - (longint'(1) << 22);
      pick = $urandom_range(0, 7);
      span[c] = (pick == 0) ? 0 : (pick < 4) ? $urandom_range(1, 255)
                                             : $urandom_range(256, 1 << 22);
    end
    for (int p = 0; p < pixels; p++)
      for (int c = 0; c < colors; c++)
        add_beat(MODE_GATHER, p == 0 && c == 0,
                 span[c] == 0 ? sample_t'(base[c]) : pick_sample(base[c], span[c]));
    for (int p = 0; p < pixels; p++)
      for (int c = 0; c < colors; c++)
        add_beat(MODE_EMIT, p == 0 && c == 0 && !broken, pick_sample(base[c], span[c]));
  endtask

  int colors_plan[10] = '{3, 1, 4, 0, 2, 5, 7, 6, 4, 1};

  initial begin
    int k;
    int cfg;
    int eff;
    int pixels;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // emit before any gather uses the reset trackers
    add_beat(MODE_EMIT, 1'b1, sample_t'(0));
    add_beat(MODE_EMIT, 1'b0, sample_t'(smp_hi()));
    add_beat(MODE_EMIT, 1'b0, sample_t'(-smp_hi() - 1));
    // full-scale range, then samples at min, mid and at max
    add_beat(MODE_GATHER, 1'b1, sample_t'(100));
    add_beat(MODE_GATHER, 1'b0, sample_t'(smp_hi()));
    add_beat(MODE_GATHER, 1'b0, sample_t'(-smp_hi() - 1));
    add_beat(MODE_EMIT, 1'b1, sample_t'(-smp_hi() - 1));
    add_beat(MODE_EMIT, 1'b0, sample_t'(0));
    add_beat(MODE_EMIT, 1'b0, sample_t'(smp_hi()));
    // narrow range: below min, inside, above max
    add_beat(MODE_GATHER, 1'b1, sample_t'(-4096));
    add_beat(MODE_GATHER, 1'b0, sample_t'(4096));
    add_beat(MODE_EMIT, 1'b1, sample_t'(-5000));
    add_beat(MODE_EMIT, 1'b0, sample_t'(1234));
    add_beat(MODE_EMIT, 1'b0, sample_t'(9000));
    // single gather sample moves max and min together: flat
    add_beat(MODE_GATHER, 1'b1, sample_t'(5));
    add_beat(MODE_EMIT, 1'b1, sample_t'(5));
    wait_idle();

    // channel count shrinks under a pass in progress
    set_colors(4);
    add_beat(MODE_GATHER, 1'b1, sample_t'(10));
    add_beat(MODE_GATHER, 1'b0, sample_t'(-20));
    add_beat(MODE_GATHER, 1'b0, sample_t'(30));
    wait_idle();
    set_colors(2);
    add_beat(MODE_GATHER, 1'b0, sample_t'(-40000));
    add_beat(MODE_GATHER, 1'b0, sample_t'(50000));
    add_beat(MODE_EMIT, 1'b1, sample_t'(0));
    add_beat(MODE_EMIT, 1'b0, sample_t'(25));
    wait_idle();

    beats_queued = 0;
    k = 0;
    while (beats_queued < RANDOM_BEATS) begin
      cfg = colors_plan[k % 10];
      eff = (cfg < 1) ? 1 : (cfg > MAX_COLORS_DEF) ? MAX_COLORS_DEF : cfg;
      set_colors(cfg);
      rx_free = ($urandom_range(0, 3) == 0);
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      pixels = $urandom_range(1, 10);
      if (k == 2) begin
        // output held off while input keeps coming: the block backs up
        gap_max = 0;
        rx_free = 1'b1;
        pixels = 8;
        hold_reqs++;
      end
      queue_image(eff, pixels, $urandom_range(0, 7) == 0);
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 6))
          add_beat(logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)),
                   sample_t'($urandom));
      wait_idle();
      k++;
    end

    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: sim.f
rtl/mmn_pkg.sv
rtl/mmn_ctrl.sv
rtl/mmn_dp.sv
rtl/minmax_normalize_to_byte_unit.sv
bench/tb_top.sv
